/* src/yaob_pkg.sv */
// Shared types and constants for the YUV420 alpha overlay blender.
`default_nettype none

package yaob_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 25;
  localparam int unsigned AddrW = 25;
  localparam int unsigned DimCfgW = 13;

  localparam logic [DimCfgW-1:0] WidthRst = 13'd1280;
  localparam logic [DimCfgW-1:0] HeightRst = 13'd720;
  localparam logic [AddrW-1:0] LengthRst = 25'd1382400;

  localparam logic [7:0] AlphaOpaque = 8'hFF;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_FRAME_LENGTH = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [7:0]  alpha;
    logic [7:0]  fg_luma;
    logic [7:0]  fg_cb;
    logic [7:0]  fg_cr;
    logic [7:0]  bg_luma;
    logic [7:0]  bg_cb;
    logic [7:0]  bg_cr;
    logic        last_in_list;
  } in_t;

  typedef struct packed {
    logic             in_frame;
    logic [AddrW-1:0] luma_addr;
    logic [AddrW-1:0] cb_addr;
    logic [AddrW-1:0] cr_addr;
    logic [7:0]       out_luma;
    logic [7:0]       out_cb;
    logic [7:0]       out_cr;
    logic             last_of_list;
  } out_t;

  // Per-stage load enables of the three-stage pipeline.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

`default_nettype wire

/* src/yaob_mix.sv */
// One-channel alpha blend pipeline: multiply, sum, divide by 255 and select.
`default_nettype none

module yaob_mix
  import yaob_pkg::*;
(
  input  wire logic      clk_i,
  input  wire stage_en_t en_i,
  input  wire logic [7:0] alpha_i,
  input  wire logic [7:0] fg_i,
  input  wire logic [7:0] bg_i,
  input  wire logic      bg_sel_i,   // stage-3 select: pass the frame byte unchanged
  output logic [7:0]     mix_o
);

  logic [15:0] prod_fg_q, prod_fg_d, prod_bg_q, prod_bg_d;
  logic        opaque1_q, opaque2_q;
  logic [7:0]  fg1_q, fg2_q, bg1_q, bg2_q;
  logic [15:0] sum_q, sum_d;
  logic [16:0] quot_wide;
  logic [7:0]  mix_q, mix_d;

  // Stage 1: both products.
  assign prod_fg_d = 16'(alpha_i) * 16'(fg_i);
  assign prod_bg_d = 16'(AlphaOpaque - alpha_i) * 16'(bg_i);

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      prod_fg_q <= prod_fg_d;
      prod_bg_q <= prod_bg_d;
      opaque1_q <= (alpha_i == AlphaOpaque);
      fg1_q     <= fg_i;
      bg1_q     <= bg_i;
    end
  end

  // Stage 2: weighted sum, at most 255*255.
  assign sum_d = prod_fg_q + prod_bg_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      sum_q     <= sum_d;
      opaque2_q <= opaque1_q;
      fg2_q     <= fg1_q;
      bg2_q     <= bg1_q;
    end
  end

  // Stage 3: floor(s/255) as (s + (s >> 8) + 1) >> 8, exact below 65535.
  assign quot_wide = 17'(sum_q) + 17'(sum_q[15:8]) + 17'd1;

  always_comb begin
    if (bg_sel_i) begin
      mix_d = bg2_q;
    end else if (opaque2_q) begin
      mix_d = fg2_q;
    end else begin
      mix_d = quot_wide[15:8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      mix_q <= mix_d;
    end
  end

  assign mix_o = mix_q;

endmodule

`default_nettype wire

/* src/yuv420_alpha_overlay_blend.sv */
// Top level of the I420 overlay pixel blender: addresses, bounds check, blend.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------
//  in      | input     | in_valid_i / in_ready_o   | in_data_i  (in_t)
//  out     | output    | out_valid_o / out_ready_i | out_data_o (out_t)
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One request enters per cycle while stage 1 can load; the depth is set by the
// multiplier stage, the adder stage and the compare/divide stage, each a register
// stage of its own.
// Reset clears the valid bits and loads the frame registers with 1280x720,
// length 1382400. The cfg port is always ready.
// A stall on the output holds only the stages that are full; bubbles close up,
// so a new request is taken while a finished result still waits.
`default_nettype none

module yuv420_alpha_overlay_blend
  import yaob_pkg::*;
#(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire in_t                 in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output out_t                     out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  // Saturated dimension width: enough for MAX_DIM, never wider than the register.
  localparam int unsigned DimNeed = $clog2(MAX_DIM + 1);
  localparam int unsigned DimW = (DimNeed < DimCfgW) ? DimNeed : DimCfgW;
  localparam int unsigned LProdW = 12 + DimW;          // pos_y * width
  localparam int unsigned CProdW = 11 + DimW - 1;      // (pos_y/2) * (width/2)
  localparam int unsigned AreaW = 2 * DimW;            // width * height
  localparam int unsigned FullA = 2 * DimW + 2;
  localparam int unsigned FullB = DimW + 14;
  localparam int unsigned FullAB = (FullA > FullB) ? FullA : FullB;
  // Full address width: no wrap for any legal dimension, at least one bit above AddrW.
  localparam int unsigned FullW = (FullAB > AddrW + 1) ? FullAB : AddrW + 1;

  // ---------------------------------------------------------------- config
  logic [DimCfgW-1:0] cfg_w_q, cfg_h_q;
  logic [AddrW-1:0]   cfg_len_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q   <= WidthRst;
      cfg_h_q   <= HeightRst;
      cfg_len_q <= LengthRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  cfg_w_q   <= cfg_data_i[DimCfgW-1:0];
        CFG_FRAME_HEIGHT: cfg_h_q   <= cfg_data_i[DimCfgW-1:0];
        CFG_FRAME_LENGTH: cfg_len_q <= cfg_data_i[AddrW-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Clamp the dimensions to MAX_DIM.
  logic [DimW-1:0] dim_w, dim_h;
  assign dim_w = (cfg_w_q > MAX_DIM) ? DimW'(MAX_DIM) : cfg_w_q[DimW-1:0];
  assign dim_h = (cfg_h_q > MAX_DIM) ? DimW'(MAX_DIM) : cfg_h_q[DimW-1:0];

  // ---------------------------------------------------------- flow control
  logic      v1_q, v2_q, v3_q;
  stage_en_t en;

  // A stage loads when it is empty or its content moves on.
  assign en.s3 = !v3_q || out_ready_i;
  assign en.s2 = !v2_q || en.s3;
  assign en.s1 = !v1_q || en.s2;
  assign in_ready_o = en.s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en.s1) v1_q <= in_valid_i;
      if (en.s2) v2_q <= v1_q;
      if (en.s3) v3_q <= v2_q;
    end
  end

  // ----------------------------------------------- stage 1: address products
  logic [LProdW-1:0] lprod1_q, lprod1_d;
  logic [CProdW-1:0] cprod1_q, cprod1_d;
  logic [AreaW-1:0]  area1_q, area1_d;
  logic [11:0]       x1_q;
  logic              last1_q;

  assign lprod1_d = LProdW'(in_data_i.pos_y) * LProdW'(dim_w);
  assign cprod1_d = CProdW'(in_data_i.pos_y[11:1]) * CProdW'(dim_w[DimW-1:1]);
  assign area1_d  = AreaW'(dim_w) * AreaW'(dim_h);

  always_ff @(posedge clk_i) begin
    if (en.s1) begin
      lprod1_q <= lprod1_d;
      cprod1_q <= cprod1_d;
      area1_q  <= area1_d;
      x1_q     <= in_data_i.pos_x;
      last1_q  <= in_data_i.last_in_list;
    end
  end

  // --------------------------------------------------- stage 2: address sums
  logic [FullW-1:0]   la2_q, la2_d, ua2_q, ua2_d;
  logic [AreaW-3:0]   qarea2_q;
  logic               last2_q;

  assign la2_d = FullW'(lprod1_q) + FullW'(x1_q);
  assign ua2_d = FullW'(cprod1_q) + FullW'(x1_q[11:1]) + FullW'(area1_q);

  always_ff @(posedge clk_i) begin
    if (en.s2) begin
      la2_q    <= la2_d;
      ua2_q    <= ua2_d;
      qarea2_q <= area1_q[AreaW-1:2];
      last2_q  <= last1_q;
    end
  end

  // ------------------------------------ stage 3: chroma V, bounds, write data
  logic [FullW-1:0] va2;
  logic             ok2;

  assign va2 = ua2_q + FullW'(qarea2_q);
  assign ok2 = (la2_q < FullW'(cfg_len_q)) && (ua2_q < FullW'(cfg_len_q))
            && (va2 < FullW'(cfg_len_q));

  logic             in_frame3_q;
  logic [AddrW-1:0] la3_q, ua3_q, va3_q;
  logic             last3_q;

  always_ff @(posedge clk_i) begin
    if (en.s3) begin
      in_frame3_q <= ok2;
      la3_q       <= la2_q[AddrW-1:0];
      ua3_q       <= ua2_q[AddrW-1:0];
      va3_q       <= va2[AddrW-1:0];
      last3_q     <= last2_q;
    end
  end

  // Blend lanes run alongside the address path; out of frame keeps the bg bytes.
  logic [7:0] mix_luma, mix_cb, mix_cr;

  yaob_mix u_mix_luma (
    .clk_i    (clk_i),
    .en_i     (en),
    .alpha_i  (in_data_i.alpha),
    .fg_i     (in_data_i.fg_luma),
    .bg_i     (in_data_i.bg_luma),
    .bg_sel_i (!ok2),
    .mix_o    (mix_luma)
  );

  yaob_mix u_mix_cb (
    .clk_i    (clk_i),
    .en_i     (en),
    .alpha_i  (in_data_i.alpha),
    .fg_i     (in_data_i.fg_cb),
    .bg_i     (in_data_i.bg_cb),
    .bg_sel_i (!ok2),
    .mix_o    (mix_cb)
  );

  yaob_mix u_mix_cr (
    .clk_i    (clk_i),
    .en_i     (en),
    .alpha_i  (in_data_i.alpha),
    .fg_i     (in_data_i.fg_cr),
    .bg_i     (in_data_i.bg_cr),
    .bg_sel_i (!ok2),
    .mix_o    (mix_cr)
  );

  assign out_valid_o = v3_q;

  always_comb begin
    out_data_o.in_frame     = in_frame3_q;
    out_data_o.luma_addr    = la3_q;
    out_data_o.cb_addr      = ua3_q;
    out_data_o.cr_addr      = va3_q;
    out_data_o.out_luma     = mix_luma;
    out_data_o.out_cb       = mix_cb;
    out_data_o.out_cr       = mix_cr;
    out_data_o.last_of_list = last3_q;
  end

  // ---------------------------------------------------------------- checks
`ifndef SYNTH
  // An accepted request always lands in the first stage.
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v1_q)
    else $error("accepted request did not enter stage 1");

  // A delivered result with nothing behind it leaves the output empty.
  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !v2_q |=> !out_valid_o)
    else $error("result repeated after delivery");

  // In-frame results carry untruncated addresses below the frame length.
  a_in_frame_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.in_frame |->
      (out_data_o.luma_addr < cfg_len_q) && (out_data_o.cr_addr < cfg_len_q))
    else $error("in_frame set with address beyond frame length");

  // V plane follows U plane whenever the item is in frame.
  a_cr_after_cb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.in_frame |-> out_data_o.cr_addr >= out_data_o.cb_addr)
    else $error("V address below U address");
`endif

endmodule

`default_nettype wire
